>>> design/itrs_pkg.sv
// shared constants, state type and digit-to-character map for the radix text converter
package itrs_pkg;

    localparam int RADIX_W   = 6;
    localparam int DIGIT_W   = 6;
    localparam int CHAR_W    = 8;
    localparam int STEP_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0] MINUS_CHAR  = 8'h2D;
    localparam logic [CHAR_W-1:0] ZERO_CHAR   = 8'h30;
    localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_LOAD  = 5'b01000,
        ST_OUT   = 5'b10000
    } itrs_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] v;
        v = (d >= RADIX_MAX) ? DIGIT_W'(d - RADIX_MAX) : d;
        if (v < DEC_DIGITS) begin
            return ZERO_CHAR + CHAR_W'(v);
        end else begin
            return LOWER_A + CHAR_W'(v - DEC_DIGITS);
        end
    endfunction

endpackage

>>> design/int_to_radix_string.sv
// signed integer to ascii text converter in radix 2..36, one character per output item
// each digit comes from the shared divider (8 quotient bits a cycle) and is stored in the digit ram,
//   then each output character, the sign included, passes through ram fetch, load and show
// a bad base skips the divider; one item at a time, s_tready high only between conversions
// reset: synchronous active-low aresetn returns the sequencer to idle; digit ram is not cleared
module int_to_radix_string #(
    parameter int VALUE_WIDTH = 32,
    localparam int S_DATA_W = ((VALUE_WIDTH + itrs_pkg::RADIX_W + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_DATA_W-1:0]         s_tdata,   // value, radix
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [itrs_pkg::CHAR_W-1:0] m_tdata,   // text_char
    output logic                        m_tlast,
    output logic [0:0]                  m_tuser    // bad_base
);

    import itrs_pkg::*;

    localparam int STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W   = STEPS * STEP_BITS;
    localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_W  = $clog2(VALUE_WIDTH);

    itrs_state_t state_reg, state_next;

    logic [PAD_W-1:0]   q_reg, q_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STEP_CW-1:0] step_reg, step_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               bad_reg, bad_next;
    logic               sign_shown_reg, sign_shown_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [RADIX_W-1:0]     in_radix;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic                   in_bad;

    logic [DIGIT_W-1:0]   div_rem;
    logic [PAD_W-1:0]     div_quo;
    logic [STEP_BITS-1:0] div_qbits;
    logic                 div_last_step;
    logic [CNT_W-1:0]     cnt_inc;

    logic                 ram_we;
    logic [DIGIT_W-1:0]   ram_rdata;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_radix = s_tdata[VALUE_WIDTH +: RADIX_W];
    assign in_mag   = in_value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - in_value) : in_value;
    assign in_bad   = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);

    // shared divider: eight restoring steps on the narrow remainder each cycle
    always_comb begin
        logic [DIGIT_W-1:0] r;
        logic [DIGIT_W:0]   t;
        r = rem_reg;
        div_qbits = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            t = {r, q_reg[PAD_W-1-i]};
            if (t >= {1'b0, radix_reg}) begin
                r = DIGIT_W'(t - {1'b0, radix_reg});
                div_qbits[STEP_BITS-1-i] = 1'b1;
            end else begin
                r = t[DIGIT_W-1:0];
            end
        end
        div_rem = r;
        div_quo = PAD_W'({q_reg, div_qbits});
    end

    assign div_last_step = (step_reg == STEP_CW'(STEPS - 1));
    assign cnt_inc       = cnt_reg + CNT_W'(1);
    assign ram_we        = (state_reg == ST_DIV) && div_last_step;

    itrs_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(VALUE_WIDTH)
    ) u_digit_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (div_rem),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        radix_next      = radix_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        bad_next        = bad_reg;
        sign_shown_next = sign_shown_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sign_shown_next = 1'b0;
                    if (in_bad) begin
                        char_next  = '0;
                        last_next  = 1'b1;
                        bad_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        q_next     = PAD_W'(in_mag);
                        rem_next   = '0;
                        radix_next = in_radix;
                        neg_next   = in_value[VALUE_WIDTH-1];
                        cnt_next   = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                q_next    = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + STEP_CW'(1);
                if (div_last_step) begin
                    cnt_next  = cnt_inc;
                    rem_next  = '0;
                    step_next = '0;
                    if ((div_quo == '0) || (cnt_inc == CNT_W'(VALUE_WIDTH))) begin
                        idx_next   = cnt_reg[ADDR_W-1:0];
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                bad_next = 1'b0;
                if (neg_reg) begin
                    char_next       = MINUS_CHAR;
                    last_next       = 1'b0;
                    neg_next        = 1'b0;
                    sign_shown_next = 1'b1;
                end else begin
                    char_next       = digit_char(ram_rdata);
                    last_next       = (idx_reg == '0);
                    sign_shown_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (!sign_shown_reg) begin
                            idx_next = idx_reg - ADDR_W'(1);
                        end
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        radix_reg      <= radix_next;
        neg_reg        <= neg_next;
        cnt_reg        <= cnt_next;
        step_reg       <= step_next;
        idx_reg        <= idx_next;
        char_reg       <= char_next;
        last_reg       <= last_next;
        bad_reg        <= bad_next;
        sign_shown_reg <= sign_shown_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = bad_reg;

endmodule

>>> design/itrs_ram.sv
// generic single-write, single-read ram with registered read data
module itrs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sim/int_to_radix_string_test.sv
// testbench for the radix text converter: directed and random items, self-checking per character
`timescale 1ns / 100ps

module int_to_radix_string_test;
    import itrs_pkg::*;

    localparam int VALUE_W   = 32;
    localparam int S_DATA_W  = ((VALUE_W + RADIX_W + 7) / 8) * 8;
    localparam int LONG_HOLD = 400;
    localparam int TAIL_CYC  = 300;
    localparam int MAX_GAP   = 20;
    localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
        logic              bad_base;
    } char_item_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [CHAR_W-1:0]   m_tdata;
    logic                m_tlast;
    logic [0:0]          m_tuser;

    char_item_t expected_chars[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    bit         hold_off_on    = 0;
    int         held_cycles    = 0;

    int_to_radix_string #(.VALUE_WIDTH(VALUE_W)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // text of one conversion, most significant character first
    function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] digit;
        logic [DIGIT_W-1:0] digits[VALUE_W];
        logic [CHAR_W-1:0]  ch;
        int                 n;
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            expected_chars.push_back('{text_char: '0, last_char: 1'b1, bad_base: 1'b1});
            return;
        end
        mag = value[VALUE_W-1] ? -value : value;
        n = 0;
        do begin
            digit = mag % VALUE_W'(radix);
            digits[n] = DIGIT_W'(digit);
            mag = mag / VALUE_W'(radix);
            n++;
        end while (mag != 0 && n < VALUE_W);
        if (value[VALUE_W-1]) begin
            expected_chars.push_back('{text_char: MINUS_CHAR, last_char: 1'b0, bad_base: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            if (digits[i] < DEC_DIGITS) begin
                ch = ZERO_CHAR + CHAR_W'(digits[i]);
            end else begin
                ch = LOWER_A + CHAR_W'(digits[i] - DEC_DIGITS);
            end
            expected_chars.push_back('{text_char: ch, last_char: (i == 0), bad_base: 1'b0});
        end
    endfunction

    // predict on each accepted item, compare each accepted character
    always @(posedge aclk) begin
        char_item_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_text(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: RADIX_W]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected item char %h last %b bad %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.text_char || m_tlast !== want.last_char
                            || m_tuser !== want.bad_base) begin
                        $display("%0t: expected char %h last %b bad %b, got char %h last %b bad %b",
                                 $time, want.text_char, want.last_char, want.bad_base,
                                 m_tdata, m_tlast, m_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, or one long hold-off when requested
    always @(posedge aclk) begin
        if (hold_off_on && held_cycles < LONG_HOLD) begin
            m_tready <= 1'b0;
            held_cycles++;
        end else begin
            if (!hold_off_on) begin
                held_cycles = 0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({radix, value});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);
    endtask

    function automatic logic [RADIX_W-1:0] pick_bad_radix;
        int r;
        r = $urandom_range(0, 28);
        return (r < 2) ? RADIX_W'(r) : RADIX_W'(r + 35);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value;
        logic [VALUE_W-1:0] v;
        case ($urandom_range(4))
            0: v = VALUE_W'($urandom_range(0, 40));
            1: v = VALUE_W'($urandom) >> $urandom_range(0, VALUE_W - 1);
            2: begin
                case ($urandom_range(3))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '1;
                    default: v = '0;
                endcase
            end
            default: v = VALUE_W'($urandom);
        endcase
        if ($urandom_range(1)) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic test_extremes;
        send_item('0, 6'd10);
        send_item(VALUE_W'(1), 6'd2);
        send_item('1, 6'd2);
        send_item(MOST_POS, RADIX_MIN);
        send_item(MOST_NEG, RADIX_MIN);
        send_item(MOST_NEG, 6'd10);
        send_item(MOST_NEG, 6'd16);
        send_item(MOST_NEG, RADIX_MAX);
        send_item(MOST_POS, RADIX_MAX);
        send_item(VALUE_W'(35), RADIX_MAX);
        send_item(-VALUE_W'(35), RADIX_MAX);
        send_item(VALUE_W'(36), RADIX_MAX);
        send_item(VALUE_W'(255), 6'd16);
        send_item(32'h5555_5555, 6'd3);
        send_item(32'hAAAA_AAAA, 6'd7);
        send_item('0, 6'd2);
        drain();
    endtask

    task automatic test_bad_base;
        send_item(VALUE_W'(123), 6'd0);
        send_item(MOST_NEG, 6'd1);
        send_item('1, 6'd37);
        send_item('0, 6'd63);
        send_item(32'h5A5A_A5A5, 6'd42);
        drain();
    endtask

    task automatic test_every_radix;
        for (int r = RADIX_MIN; r <= RADIX_MAX; r++) begin
            send_item(VALUE_W'($urandom), RADIX_W'(r));
        end
        drain();
    endtask

    task automatic test_random(input int count);
        logic [RADIX_W-1:0] radix;
        for (int i = 0; i < count; i++) begin
            radix = ($urandom_range(99) < 10) ? pick_bad_radix()
                                              : RADIX_W'($urandom_range(2, 36));
            send_item(pick_value(), radix);
        end
        drain();
    endtask

    task automatic test_output_backpressure;
        hold_off_on = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_item(VALUE_W'($urandom), RADIX_MIN);
        end
        drain();
        hold_off_on = 1'b0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_idle_pct = 9;
        recv_idle_pct = 70;
        test_extremes();
        test_bad_base();
        test_every_radix();
        test_random(72);

        send_idle_pct = 70;
        recv_idle_pct = 9;
        test_random(72);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(72);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
